### rtl/bmf_pkg.sv
// Shared types and constants of the box mean filter.
// Holds field widths, register indexes and the pixel pipeline record.
// No dependencies; every other file imports this package.
package bmf_pkg;

   localparam int CH_W         = 8;
   localparam int NUM_COLOR    = 3;
   localparam int PIX_W        = 4 * CH_W;
   localparam int ALPHA_LSB    = NUM_COLOR * CH_W;
   localparam int COL_W        = 10;
   localparam int ROW_W        = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int RESET_WIDTH  = 1024;
   localparam int RESET_HEIGHT = 1024;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int DEF_RADIUS    = 1;

   localparam int REQ_TDATA_W = PIX_W;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = HEIGHT_REG_W;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_idx_type;

   // One pixel as it travels down the pipeline, with both of its possible results.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] int_col;
      logic [ROW_W-1:0] int_row;
      logic             is_int;
      logic             is_bord;
      logic [PIX_W-1:0] pix;
   } meta_type;

   // One result; the first member lands in the highest bits, so col is lowest.
   typedef struct packed {
      logic [CH_W-1:0]  alpha;
      logic [CH_W-1:0]  blue;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  red;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } rsp_item_type;

   localparam int RSP_PAD_W = RSP_TDATA_W - $bits(rsp_item_type);

endpackage

### rtl/bmf_line_buffer.sv
// Line store of the box mean filter: one word per column holding the last
// 2*RADIUS rows of that column, with a bypass for a read of the word being written.
// Depends on bmf_pkg.
module bmf_line_buffer import bmf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int RADIUS    = DEF_RADIUS,
   localparam int AW       = $clog2(MAX_WIDTH),
   localparam int WORD_W   = 2 * RADIUS * PIX_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem_ff [MAX_WIDTH];
   logic [WORD_W-1:0] mem_q_ff;
   logic [WORD_W-1:0] byp_data_ff;
   logic              byp_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff    <= mem_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // The array returns the old word when read and write meet on one address.
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_hit_ff <= 1'b0;
      end else if (rd_en) begin
         byp_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : mem_q_ff;

endmodule

### rtl/bmf_window.sv
// Sliding window of the box mean filter, kept as per-column channel sums and
// a running window sum, plus the alpha of the center row. Depends on bmf_pkg.
module bmf_window import bmf_pkg::*; #(
   parameter int RADIUS  = DEF_RADIUS,
   localparam int SPAN   = 2 * RADIUS + 1,
   localparam int SUM_W  = $clog2(SPAN * SPAN * 255 + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 col_en,
   input  logic                                 win_en,
   input  logic [SPAN*PIX_W-1:0]                col_pix,
   output logic [NUM_COLOR-1:0][SUM_W-1:0]      win_sum,
   output logic [CH_W-1:0]                      win_alpha
);

   localparam int CS_W = $clog2(SPAN * 255 + 1);

   logic [NUM_COLOR-1:0][CS_W-1:0]  cs_in;
   logic [NUM_COLOR-1:0][CS_W-1:0]  cs_new_ff;
   logic [CH_W-1:0]                 ca_ff;
   logic [NUM_COLOR-1:0][CS_W-1:0]  cs_sr_ff [SPAN];
   logic [CH_W-1:0]                 al_sr_ff [SPAN];
   logic [NUM_COLOR-1:0][SUM_W-1:0] win_sum_ff;
   logic [NUM_COLOR-1:0][SUM_W-1:0] win_sum_in;
   logic [CH_W-1:0]                 win_alpha_ff;

   // Sum of the arriving column, one adder chain per channel.
   always_comb begin
      cs_in = '0;
      for (int ch = 0; ch < NUM_COLOR; ch++) begin
         for (int k = 0; k < SPAN; k++) begin
            cs_in[ch] = cs_in[ch] + CS_W'(col_pix[k*PIX_W + ch*CH_W +: CH_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (col_en) begin
         cs_new_ff <= cs_in;
         ca_ff     <= col_pix[RADIUS*PIX_W + ALPHA_LSB +: CH_W];
      end
   end

   // The new column enters, the oldest one leaves the running sum.
   always_comb begin
      for (int ch = 0; ch < NUM_COLOR; ch++) begin
         win_sum_in[ch] = win_sum_ff[ch] + SUM_W'(cs_new_ff[ch]) - SUM_W'(cs_sr_ff[0][ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SPAN; k++) begin
            cs_sr_ff[k] <= '0;
            al_sr_ff[k] <= '0;
         end
         win_sum_ff <= '0;
      end else if (win_en) begin
         for (int k = 0; k < SPAN - 1; k++) begin
            cs_sr_ff[k] <= cs_sr_ff[k+1];
            al_sr_ff[k] <= al_sr_ff[k+1];
         end
         cs_sr_ff[SPAN-1] <= cs_new_ff;
         al_sr_ff[SPAN-1] <= ca_ff;
         win_sum_ff       <= win_sum_in;
      end
   end

   // After the shift the center column sits where column RADIUS+1 is now.
   always_ff @(posedge clock) begin
      if (win_en) begin
         win_alpha_ff <= al_sr_ff[RADIUS+1];
      end
   end

   assign win_sum   = win_sum_ff;
   assign win_alpha = win_alpha_ff;

endmodule

### rtl/bmf_mean_div.sv
// Truncating division of the window sums by the window area, done as a
// multiplication by a rounded-up reciprocal and a shift. Depends on bmf_pkg.
module bmf_mean_div import bmf_pkg::*; #(
   parameter int RADIUS  = DEF_RADIUS,
   localparam int SPAN   = 2 * RADIUS + 1,
   localparam int SUM_W  = $clog2(SPAN * SPAN * 255 + 1)
) (
   input  logic                            clock,
   input  logic                            mul_en,
   input  logic [NUM_COLOR-1:0][SUM_W-1:0] win_sum,
   input  logic [CH_W-1:0]                 win_alpha,
   output logic [NUM_COLOR-1:0][CH_W-1:0]  mean,
   output logic [CH_W-1:0]                 mean_alpha
);

   localparam int AREA   = SPAN * SPAN;
   localparam int SHIFT  = SUM_W + $clog2(AREA);
   localparam int RECIP  = ((2 ** SHIFT) + AREA - 1) / AREA;
   localparam int PROD_W = 2 * SUM_W + 1;

   logic [NUM_COLOR-1:0][PROD_W-1:0] prod_ff;
   logic [CH_W-1:0]                  alpha_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         for (int ch = 0; ch < NUM_COLOR; ch++) begin
            prod_ff[ch] <= PROD_W'(win_sum[ch]) * PROD_W'(RECIP);
         end
         alpha_ff <= win_alpha;
      end
   end

   always_comb begin
      for (int ch = 0; ch < NUM_COLOR; ch++) begin
         mean[ch] = prod_ff[ch][SHIFT +: CH_W];
      end
   end

   assign mean_alpha = alpha_ff;

endmodule

### rtl/bmf_out_stage.sv
// Result register of the box mean filter: holds the interior and the border
// result of one pixel and hands them out in that order. Depends on bmf_pkg.
module bmf_out_stage import bmf_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  meta_type                       in_meta,
   input  logic [NUM_COLOR-1:0][CH_W-1:0] mean,
   input  logic [CH_W-1:0]                mean_alpha,
   output logic                           load_ok,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                           rsp_tlast
);

   logic         int_pend_ff;
   logic         int_pend_in;
   logic         bord_pend_ff;
   logic         bord_pend_in;
   rsp_item_type int_data_ff;
   rsp_item_type bord_data_ff;
   rsp_item_type show;

   assign rsp_tvalid = int_pend_ff || bord_pend_ff;
   assign rsp_tlast  = int_pend_ff ? !bord_pend_ff : 1'b1;
   assign show       = int_pend_ff ? int_data_ff : bord_data_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, show};
   assign load_ok    = !rsp_tvalid || (rsp_tready && rsp_tlast);

   always_comb begin
      int_pend_in  = int_pend_ff;
      bord_pend_in = bord_pend_ff;
      if (load) begin
         int_pend_in  = in_meta.is_int;
         bord_pend_in = in_meta.is_bord;
      end else if (rsp_tvalid && rsp_tready) begin
         if (int_pend_ff) begin
            int_pend_in = 1'b0;
         end else begin
            bord_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_pend_ff  <= 1'b0;
         bord_pend_ff <= 1'b0;
      end else begin
         int_pend_ff  <= int_pend_in;
         bord_pend_ff <= bord_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         int_data_ff.col    <= in_meta.int_col;
         int_data_ff.row    <= in_meta.int_row;
         int_data_ff.red    <= mean[0];
         int_data_ff.green  <= mean[1];
         int_data_ff.blue   <= mean[2];
         int_data_ff.alpha  <= mean_alpha;
         bord_data_ff.col   <= in_meta.col;
         bord_data_ff.row   <= in_meta.row;
         bord_data_ff.red   <= in_meta.pix[0*CH_W +: CH_W];
         bord_data_ff.green <= in_meta.pix[1*CH_W +: CH_W];
         bord_data_ff.blue  <= in_meta.pix[2*CH_W +: CH_W];
         bord_data_ff.alpha <= in_meta.pix[ALPHA_LSB +: CH_W];
      end
   end

endmodule

### rtl/box_mean_filter_unit.sv
// Box mean filter over RGBA pixels in raster order, (2*RADIUS+1) square window.
// Top level; uses bmf_pkg, bmf_line_buffer, bmf_window, bmf_mean_div and bmf_out_stage.
//
// Usage:
//   Pixels enter on the req_ stream one per request, in raster order, for a frame
//   of frame_width by frame_height pixels set through the csr_ write channel
//   (index 0 is frame_width, index 1 is frame_height). A write to either register restarts
//   the frame at column 0, row 0; write only while the block is drained.
//   Each pixel yields zero, one or two results on the rsp_ stream. When the pixel
//   completes the window of an interior pixel, that pixel's mean comes first. When
//   the pixel itself lies within RADIUS of a border, it follows unchanged. rsp_tlast
//   marks the last result caused by one request.
//   An accepted request passes stages p1, p2, p3 and p4 before its first result is
//   loaded into the output register. The block takes one request every cycle while
//   the receiver keeps up; a pixel that yields two results holds the output register
//   until both are taken, which can stall the input through the pipeline's ready chain.
//   When the receiver drops rsp_tready, the pipeline fills and then req_tready
//   falls; nothing is lost or repeated.
//   Reset clears the raster position, the window sums and all valid flags, and sets
//   both frame dimensions to 1024 (width limited to MAX_WIDTH). The line store is
//   not cleared; rows above the top of the frame enter the window as zero, and rows
//   are always written in a frame before they reach a result.
module box_mean_filter_unit import bmf_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int RADIUS    = DEF_RADIUS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // col[9:0], row[21:10], red[29:22],
                                               // green[37:30], blue[45:38], alpha[53:46]
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LINES = 2 * RADIUS;
   localparam int SPAN  = LINES + 1;
   localparam int CCW   = $clog2(MAX_WIDTH);
   localparam int LB_W  = LINES * PIX_W;
   localparam int SUM_W = $clog2(SPAN * SPAN * 255 + 1);
   localparam int RST_W = (RESET_WIDTH < MAX_WIDTH) ? RESET_WIDTH : MAX_WIDTH;
   localparam logic [CCW-1:0]        RST_W_LAST = CCW'(RST_W - 1);
   localparam logic [ROW_W-1:0]      RST_H_LAST = ROW_W'(RESET_HEIGHT - 1);
   localparam logic [CSR_DATA_W-1:0] MAX_W_V    = CSR_DATA_W'(MAX_WIDTH);
   localparam logic [CSR_DATA_W-1:0] MAX_H_V    = CSR_DATA_W'(MAX_HEIGHT);

   // Raster position and the clamped frame size, kept as last column and last row.
   logic [CCW-1:0]   col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CCW-1:0]   w_last_ff, w_last_in;
   logic [ROW_W-1:0] h_last_ff, h_last_in;

   logic                  csr_fire;
   logic [CSR_DATA_W-1:0] w_raw, w_eff, h_raw, h_eff;
   logic                  accept;

   // Pipeline: p1 reads the line store, p2 holds the column sum, p3 the window
   // sum, p4 the scaled product; the output stage follows.
   logic     p1_v_ff, p2_v_ff, p3_v_ff, p4_v_ff;
   meta_type s0_meta, p1_meta_ff, p2_meta_ff, p3_meta_ff, p4_meta_ff;
   logic [CCW-1:0] p1_addr_ff;
   logic     rdy1, rdy2, rdy3, rdy4;
   logic     fire1, fire2, fire3, fire4;
   logic     out_load_ok;

   logic [LB_W-1:0]                 lb_word;
   logic [LB_W-1:0]                 lb_live;
   logic [LB_W-1:0]                 lb_wdata;
   logic [SPAN*PIX_W-1:0]           col_vec;
   logic [NUM_COLOR-1:0][SUM_W-1:0] win_sum;
   logic [CH_W-1:0]                 win_alpha;
   logic [NUM_COLOR-1:0][CH_W-1:0]  mean;
   logic [CH_W-1:0]                 mean_alpha;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Ready chain: a stage takes a new request when it is empty or moving on.
   assign rdy4  = !p4_v_ff || out_load_ok;
   assign rdy3  = !p3_v_ff || rdy4;
   assign rdy2  = !p2_v_ff || rdy3;
   assign rdy1  = !p1_v_ff || rdy2;
   assign fire1 = p1_v_ff && rdy2;
   assign fire2 = p2_v_ff && rdy3;
   assign fire3 = p3_v_ff && rdy4;
   assign fire4 = p4_v_ff && out_load_ok;

   assign req_tready = rdy1;
   assign accept     = req_tvalid && rdy1;

   // Register writes are clamped once here: zero acts as one, oversize as the limit.
   always_comb begin
      w_raw = CSR_DATA_W'(csr_wdata[WIDTH_REG_W-1:0]);
      h_raw = csr_wdata[HEIGHT_REG_W-1:0];
      if (w_raw == '0) begin
         w_eff = CSR_DATA_W'(1);
      end else if (w_raw > MAX_W_V) begin
         w_eff = MAX_W_V;
      end else begin
         w_eff = w_raw;
      end
      if (h_raw == '0) begin
         h_eff = CSR_DATA_W'(1);
      end else if (h_raw > MAX_H_V) begin
         h_eff = MAX_H_V;
      end else begin
         h_eff = h_raw;
      end
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      w_last_in = w_last_ff;
      h_last_in = h_last_ff;
      if (csr_fire) begin
         case (csr_addr)
            CSR_FRAME_WIDTH: begin
               w_last_in = CCW'(w_eff - 1'b1);
               col_in    = '0;
               row_in    = '0;
            end
            CSR_FRAME_HEIGHT: begin
               h_last_in = ROW_W'(h_eff - 1'b1);
               col_in    = '0;
               row_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = (row_ff == h_last_ff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         w_last_ff <= RST_W_LAST;
         h_last_ff <= RST_H_LAST;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         w_last_ff <= w_last_in;
         h_last_ff <= h_last_in;
      end
   end

   // An interior pixel completes once LINES rows and columns precede the arrival;
   // the arriving pixel itself is a border pixel when it sits within RADIUS of an edge.
   always_comb begin
      s0_meta.col     = COL_W'(col_ff);
      s0_meta.row     = row_ff;
      s0_meta.int_col = COL_W'(32'(col_ff) - RADIUS);
      s0_meta.int_row = ROW_W'(32'(row_ff) - RADIUS);
      s0_meta.is_int  = (32'(col_ff) >= LINES) && (32'(row_ff) >= LINES);
      s0_meta.is_bord = (32'(col_ff) < RADIUS) || (32'(col_ff) + RADIUS > 32'(w_last_ff)) ||
                        (32'(row_ff) < RADIUS) || (32'(row_ff) + RADIUS > 32'(h_last_ff));
      s0_meta.pix     = req_tdata[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
         p4_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            p1_v_ff <= accept;
         end
         if (rdy2) begin
            p2_v_ff <= fire1;
         end
         if (rdy3) begin
            p3_v_ff <= fire2;
         end
         if (rdy4) begin
            p4_v_ff <= fire3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p1_meta_ff <= s0_meta;
         p1_addr_ff <= col_ff;
      end
      if (rdy2) begin
         p2_meta_ff <= p1_meta_ff;
      end
      if (rdy3) begin
         p3_meta_ff <= p2_meta_ff;
      end
      if (rdy4) begin
         p4_meta_ff <= p3_meta_ff;
      end
   end

   // A stored row that lies above the top of the current frame may never have
   // been written, so it enters the column as zero. Such rows never reach an
   // interior result, which needs LINES rows of this frame above it.
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         lb_live[k*PIX_W +: PIX_W] = (32'(p1_meta_ff.row) + k >= LINES) ?
                                     lb_word[k*PIX_W +: PIX_W] : '0;
      end
   end

   // Each column word is a vertical shift line: the oldest row drops out at the
   // bottom and the new pixel enters at the top when it is written back.
   assign col_vec  = {p1_meta_ff.pix, lb_live};
   assign lb_wdata = {p1_meta_ff.pix, lb_live[LB_W-1:PIX_W]};

   bmf_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH),
      .RADIUS    (RADIUS)
   ) u_line_buffer (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (fire1),
      .wr_addr (p1_addr_ff),
      .wr_data (lb_wdata),
      .rd_data (lb_word)
   );

   bmf_window #(
      .RADIUS (RADIUS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .col_en    (fire1),
      .win_en    (fire2),
      .col_pix   (col_vec),
      .win_sum   (win_sum),
      .win_alpha (win_alpha)
   );

   bmf_mean_div #(
      .RADIUS (RADIUS)
   ) u_mean_div (
      .clock      (clock),
      .mul_en     (fire3),
      .win_sum    (win_sum),
      .win_alpha  (win_alpha),
      .mean       (mean),
      .mean_alpha (mean_alpha)
   );

   bmf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire4),
      .in_meta    (p4_meta_ff),
      .mean       (mean),
      .mean_alpha (mean_alpha),
      .load_ok    (out_load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### verif/tb.sv
// Self-checking testbench for the box mean filter unit (box_mean_filter_unit).
// It predicts every filtered or passed-through pixel and checks each response in order.
// Depends on bmf_pkg and the RTL of the block.
`timescale 1ns / 1ps

import bmf_pkg::*;

// One expected response: the pixel record and its end-of-request flag.
typedef struct packed {
   logic         last;
   rsp_item_type px;
} out_pixel_type;

// Tracks frame geometry, line store and window, and holds the responses due next.
class box_filter_checker;
   localparam int SPAN  = 2 * DEF_RADIUS + 1;
   localparam int LINES = 2 * DEF_RADIUS;

   logic [PIX_W-1:0]        line_mem [LINES * DEF_MAX_WIDTH];
   logic [PIX_W-1:0]        win [SPAN][SPAN];
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   int                      col_pos;
   int                      row_pos;
   int                      errors;
   out_pixel_type           due_pixels [$];

   function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[r, c]) win[r][c] = '0;
      width_reg  = WIDTH_REG_W'(RESET_WIDTH);
      height_reg = HEIGHT_REG_W'(RESET_HEIGHT);
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
   endfunction

   function int pending();
      return due_pixels.size();
   endfunction

   // A write to either frame register restarts the raster; other indexes do nothing.
   function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
         CSR_FRAME_HEIGHT: height_reg = data;
         default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
   endfunction

   function void take_pixel(logic [PIX_W-1:0] pix);
      int            w;
      int            h;
      int            n;
      int            sum [NUM_COLOR];
      out_pixel_type found [2];

      w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      n = 0;

      // Slide the window left and load the new column from the line store.
      for (int r = 0; r < SPAN; r++)
         for (int c = 0; c < SPAN - 1; c++)
            win[r][c] = win[r][c+1];
      for (int r = 0; r < LINES; r++)
         win[r][SPAN-1] = line_mem[((row_pos + r) % LINES) * DEF_MAX_WIDTH + col_pos];
      win[SPAN-1][SPAN-1] = pix;
      line_mem[(row_pos % LINES) * DEF_MAX_WIDTH + col_pos] = pix;

      // The window now covers an interior pixel: its mean goes out first.
      if (col_pos >= LINES && row_pos >= LINES) begin
         for (int ch = 0; ch < NUM_COLOR; ch++) begin
            sum[ch] = 0;
            foreach (win[r, c]) sum[ch] += win[r][c][ch*CH_W +: CH_W];
         end
         found[n].px.col   = COL_W'(col_pos - DEF_RADIUS);
         found[n].px.row   = ROW_W'(row_pos - DEF_RADIUS);
         found[n].px.red   = CH_W'(sum[0] / (SPAN * SPAN));
         found[n].px.green = CH_W'(sum[1] / (SPAN * SPAN));
         found[n].px.blue  = CH_W'(sum[2] / (SPAN * SPAN));
         found[n].px.alpha = win[DEF_RADIUS][DEF_RADIUS][ALPHA_LSB +: CH_W];
         n++;
      end

      // A pixel near any edge passes through untouched.
      if (col_pos < DEF_RADIUS || col_pos + DEF_RADIUS >= w ||
          row_pos < DEF_RADIUS || row_pos + DEF_RADIUS >= h) begin
         found[n].px.col   = COL_W'(col_pos);
         found[n].px.row   = ROW_W'(row_pos);
         found[n].px.red   = pix[0 +: CH_W];
         found[n].px.green = pix[CH_W +: CH_W];
         found[n].px.blue  = pix[2*CH_W +: CH_W];
         found[n].px.alpha = pix[ALPHA_LSB +: CH_W];
         n++;
      end

      for (int i = 0; i < n; i++) begin
         found[i].last = (i == n - 1);
         due_pixels.push_back(found[i]);
      end

      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_output_pixel(logic [RSP_TDATA_W-1:0] data, logic last_flag);
      out_pixel_type want;
      rsp_item_type  got;

      got = data[$bits(rsp_item_type)-1:0];
      if (due_pixels.size() == 0) begin
         $display("%0t ns: unexpected response, expected none actual col %0d row %0d",
                  $time, got.col, got.row);
         errors++;
         return;
      end
      want = due_pixels.pop_front();
      compare_field("col", want.px.col, got.col);
      compare_field("row", want.px.row, got.row);
      compare_field("red", want.px.red, got.red);
      compare_field("green", want.px.green, got.green);
      compare_field("blue", want.px.blue, got.blue);
      compare_field("alpha", want.px.alpha, got.alpha);
      compare_field("pad", 0, 32'(data >> $bits(rsp_item_type)));
      compare_field("tlast", want.last, last_flag);
   endfunction
endclass

module tb;

   // Cycles the receiver holds off once so that the pipeline fills and
   // req_tready has to fall.
   localparam int HOLD_CYCLES    = 400;
   // Quiet cycles after the last response before a register write or the end;
   // a request that completes nothing may still be in the four-stage pipe.
   localparam int DRAIN_CYCLES   = 12;
   // Cycles without any accepted request, response or register write before
   // the run is declared hung. It has to outlast the hold-off above.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_ITEMS   = 160;

   // Register index the block does not decode; a write there must be ignored.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_IDX = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // col[9:0], row[21:10], red[29:22],
                                             // green[37:30], blue[45:38], alpha[53:46]
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   box_filter_checker filter_chk;

   // Set by the stimulus, cleared by the receiver once it starts the long hold-off.
   bit hold_req = 1'b0;
   int send_burst = 0;

   box_mean_filter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Wait before the next handshake: usually a random pause, with occasional
   // stretches of back-to-back transfers.
   function automatic int draw_wait(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   // All observation happens on the rising edge, on values from before the edge,
   // so the order of processes within the time step does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) filter_chk.write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) filter_chk.take_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) filter_chk.check_output_pixel(rsp_tdata, rsp_tlast);
      end
   end

   // Receiver: stalls a random number of cycles before each response, and once
   // for a long stretch when asked.
   initial begin
      int wait_cycles;
      int burst_left;
      burst_left = 0;
      forever begin
         if (hold_req) begin
            hold_req    = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end else begin
            wait_cycles = draw_wait(burst_left);
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: any accepted transfer restarts the count.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: FAIL");
      $finish;
   end

   // Offer one pixel request after a random gap and hold it until accepted.
   // With no gap, tvalid simply stays high for the next request.
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      gap = draw_wait(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
   endtask

   // Pixels are either fully random or, in some frames, all-zero and all-ones
   // words, which pushes the window sums to their limits.
   task automatic send_pixels(input int count, input bit saturate);
      for (int i = 0; i < count; i++)
         send_pixel(saturate ? ($urandom_range(0, 1) ? '1 : '0) : $urandom());
   endtask

   // Stop offering requests and wait until every predicted response has come
   // back, plus a few cycles for requests that produce nothing. The first edge
   // lets the monitor note the request accepted in this time step.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (filter_chk.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Present one register write and wait for it; csr_valid stays high so that
   // a second write can follow on the next cycle.
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_frame_size(input logic [CSR_DATA_W-1:0] width_data,
                                 input logic [CSR_DATA_W-1:0] height_data);
      write_csr(CSR_FRAME_WIDTH, width_data);
      write_csr(CSR_FRAME_HEIGHT, height_data);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int random_sent;
      int w_eff;
      int h_eff;
      int count;
      logic [CSR_DATA_W-1:0] width_data;
      logic [CSR_DATA_W-1:0] height_data;

      filter_chk = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry is 1024 x 1024, so the first row passes straight through.
      // Channel extremes go in first.
      send_pixel('0);
      send_pixel('1);
      send_pixel(32'h5A3C_C3A5);
      drain();

      // A write to an index that holds no register must not restart the frame:
      // the next request still lands in column 3 of row 0.
      write_csr(CSR_SPARE_IDX, '1);
      csr_valid <= 1'b0;
      send_pixel(32'h8001_7F80);
      drain();

      // Smallest frame with an interior pixel. One dark corner makes the mean
      // truncate (2040 / 9); the second frame checks the wrap at frame end.
      set_frame_size(CSR_DATA_W'(3), CSR_DATA_W'(3));
      send_pixel('0);
      for (int i = 1; i < 9; i++) send_pixel('1);
      send_pixels(9, 1'b0);
      drain();

      // Zero dimensions act as one: every pixel is copied at column 0, row 0.
      set_frame_size('0, '0);
      send_pixels(2, 1'b0);
      drain();

      // Full-width frame: the start of its first row passes through.
      set_frame_size(CSR_DATA_W'(DEF_MAX_WIDTH), CSR_DATA_W'(3));
      send_pixels(12, 1'b0);
      drain();

      // A width above the maximum is limited to it.
      set_frame_size(13'h07FF, CSR_DATA_W'(2));
      send_pixels(6, 1'b0);
      drain();

      // The largest height register value acts as 4096 rows; one-pixel rows
      // step the row count with every request.
      set_frame_size(CSR_DATA_W'(1), 13'h1FFF);
      send_pixels(8, 1'b0);
      drain();

      set_frame_size(CSR_DATA_W'(1), CSR_DATA_W'(MAX_HEIGHT));
      send_pixels(3, 1'b0);
      drain();

      // Random part: mostly complete small frames with random content, some
      // back-to-back frames, some frames cut short, and now and then odd or
      // oversized geometry. The first frame runs under the long hold-off.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       width_data = '0;
            1:       width_data = CSR_DATA_W'($urandom());
            default: width_data = CSR_DATA_W'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       height_data = '0;
            1:       height_data = CSR_DATA_W'($urandom());
            default: height_data = CSR_DATA_W'($urandom_range(1, 8));
         endcase
         if (random_sent == 0) begin
            width_data  = CSR_DATA_W'(8);
            height_data = CSR_DATA_W'(8);
         end
         w_eff = width_data[WIDTH_REG_W-1:0];
         w_eff = (w_eff == 0) ? 1 : ((w_eff > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_eff);
         h_eff = (height_data == 0) ? 1 :
                 ((height_data > MAX_HEIGHT) ? MAX_HEIGHT : height_data);

         if (w_eff * h_eff > 100 || $urandom_range(0, 5) == 0)
            count = $urandom_range(1, 40);
         else if ($urandom_range(0, 4) == 0)
            count = 2 * w_eff * h_eff;
         else
            count = w_eff * h_eff;

         set_frame_size(width_data, height_data);
         if (random_sent == 0) hold_req = 1'b1;
         send_pixels(count, $urandom_range(0, 7) == 0);
         random_sent += count;
         drain();
      end

      if (filter_chk.errors == 0 && filter_chk.pending() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
